// ===== rtl/wwa_pkg.sv =====
// -----------------------------------------------------------------------------
// wwa_pkg
// Shared widths, reset values and register codes for the windowed and
// weighted average core.
// -----------------------------------------------------------------------------
package wwa_pkg;

    localparam int SAMPLE_W           = 16;
    localparam int CNT_W              = 5;
    // Sum of up to 2^CNT_W - 1 samples
    localparam int SUM_W              = SAMPLE_W + CNT_W;
    localparam int DEFAULT_MAX_WINDOW = 16;
    localparam int QUEUE_DEPTH        = 2;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    localparam logic [CNT_W-1:0]     WINDOW_SIZE_RESET = CNT_W'(8);
    localparam logic [REG_IDX_W-1:0] REG_WINDOW_SIZE   = REG_IDX_W'(0);

endpackage

// ===== rtl/wwa_front.sv =====
// -----------------------------------------------------------------------------
// wwa_front
// Holds the window size register and the window bookkeeping (fill count and
// oldest slot). Places each accepted sample and hands a job to the queue.
// -----------------------------------------------------------------------------
module wwa_front
    import wwa_pkg::*;
#(
    parameter int MAX_WINDOW = DEFAULT_MAX_WINDOW,
    parameter int IDX_W      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1,
    parameter int JOB_W      = SAMPLE_W + 2 * IDX_W + CNT_W
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [SAMPLE_W-1:0]   sample,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic                  push,
    output logic [JOB_W-1:0]      push_data,
    input  logic                  q_full
);

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic [IDX_W-1:0]    slot;
        logic [IDX_W-1:0]    base;
        logic [CNT_W-1:0]    count;
    } job_t;

    localparam int PW = ((IDX_W > CNT_W) ? IDX_W : CNT_W) + 1;
    localparam int CNT_LIMIT = (1 << CNT_W) - 1;
    localparam logic [CNT_W-1:0] MAX_CNT =
        (MAX_WINDOW > CNT_LIMIT) ? CNT_W'(CNT_LIMIT) : CNT_W'(MAX_WINDOW);
    localparam logic [PW-1:0]    MAX_P   = PW'(MAX_WINDOW);

    logic [CNT_W-1:0] win_reg,    win_next;
    logic [CNT_W-1:0] fill_reg,   fill_next;
    logic [IDX_W-1:0] oldest_reg, oldest_next;

    logic [REG_IDX_W-1:0] reg_idx;
    logic                 cfg_wr;
    logic                 accept;
    logic [CNT_W-1:0]     eff_win;
    logic [PW-1:0]        slot_sum;
    logic [PW-1:0]        slot_wrap;
    logic [PW-1:0]        old_inc;
    logic [IDX_W-1:0]     wr_slot;
    job_t                 job;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready && (reg_idx == REG_WINDOW_SIZE);
    assign prdata  = (reg_idx == REG_WINDOW_SIZE) ?
                     {{(APB_DATA_W-CNT_W){1'b0}}, win_reg} : '0;

    assign in_stall = q_full;
    assign accept   = in_valid && !in_stall;
    assign push     = accept;

    always_comb
    begin
        if (win_reg == '0)
            eff_win = CNT_W'(1);
        else if (win_reg > MAX_CNT)
            eff_win = MAX_CNT;
        else
            eff_win = win_reg;
    end

    // Circular index arithmetic: sums stay below twice the depth
    assign slot_sum  = PW'(oldest_reg) + PW'(fill_reg);
    assign slot_wrap = (slot_sum >= MAX_P) ? (slot_sum - MAX_P) : slot_sum;
    assign old_inc   = (PW'(oldest_reg) + PW'(1) >= MAX_P) ? '0 : PW'(oldest_reg) + PW'(1);

    always_comb
    begin
        fill_next   = fill_reg;
        oldest_next = oldest_reg;
        win_next    = win_reg;
        if (fill_reg < eff_win)
            wr_slot = slot_wrap[IDX_W-1:0];
        else
            wr_slot = oldest_reg;
        if (cfg_wr)
        begin
            win_next    = pwdata[CNT_W-1:0];
            fill_next   = '0;
            oldest_next = '0;
        end
        else if (accept)
        begin
            if (fill_reg < eff_win)
                fill_next = fill_reg + CNT_W'(1);
            else
                oldest_next = old_inc[IDX_W-1:0];
        end
    end

    always_comb
    begin
        job.sample = sample;
        job.slot   = wr_slot;
        job.base   = oldest_next;
        job.count  = fill_next;
    end

    assign push_data = job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg    <= WINDOW_SIZE_RESET;
            fill_reg   <= '0;
            oldest_reg <= '0;
        end
        else
        begin
            win_reg    <= win_next;
            fill_reg   <= fill_next;
            oldest_reg <= oldest_next;
        end
    end

endmodule

// ===== rtl/wwa_queue.sv =====
// -----------------------------------------------------------------------------
// wwa_queue
// Short first-in first-out queue of jobs between front and back.
// -----------------------------------------------------------------------------
module wwa_queue
    import wwa_pkg::*;
#(
    parameter int DATA_W = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              full,
    input  logic              pop,
    output logic [DATA_W-1:0] pop_data,
    output logic              empty
);

    localparam int QP_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    logic [DATA_W-1:0] entry_reg [QUEUE_DEPTH];
    logic [QP_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QP_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QP_W:0]     level_reg,  level_next;

    assign full     = (level_reg == (QP_W+1)'(QUEUE_DEPTH));
    assign empty    = (level_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (push && !full)
        begin
            wr_ptr_next = (wr_ptr_reg == QP_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + QP_W'(1);
        end
        if (pop && !empty)
        begin
            rd_ptr_next = (rd_ptr_reg == QP_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + QP_W'(1);
        end
        if ((push && !full) && !(pop && !empty))
            level_next = level_reg + (QP_W+1)'(1);
        else if (!(push && !full) && (pop && !empty))
            level_next = level_reg - (QP_W+1)'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

endmodule

// ===== rtl/wwa_back.sv =====
// -----------------------------------------------------------------------------
// wwa_back
// Owns the sample store. Writes each job's sample, walks the window from the
// oldest entry for sum and weighted average, divides the sum serially by the
// count and holds the result in the output register.
// -----------------------------------------------------------------------------
module wwa_back
    import wwa_pkg::*;
#(
    parameter int MAX_WINDOW = DEFAULT_MAX_WINDOW,
    parameter int IDX_W      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1,
    parameter int JOB_W      = SAMPLE_W + 2 * IDX_W + CNT_W
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  logic [JOB_W-1:0]    pop_data,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [SAMPLE_W-1:0] mean_value,
    output logic [SAMPLE_W-1:0] weighted_value
);

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic [IDX_W-1:0]    slot;
        logic [IDX_W-1:0]    base;
        logic [CNT_W-1:0]    count;
    } job_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DIV,
        ST_FINISH
    } state_t;

    localparam int PW   = ((IDX_W > CNT_W) ? IDX_W : CNT_W) + 1;
    localparam int BC_W = $clog2(SUM_W);
    localparam logic [PW-1:0] MAX_P = PW'(MAX_WINDOW);

    job_t job;

    logic [SAMPLE_W-1:0] mem_reg [MAX_WINDOW];
    logic [SAMPLE_W-1:0] rd_data_reg;

    state_t           state_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [IDX_W-1:0] base_reg;
    logic [CNT_W-1:0] rd_idx_reg;
    logic             data_vld_reg;
    logic             data_last_reg;
    logic             first_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [SAMPLE_W-1:0] acc_reg;
    logic             neg_reg;
    logic [SUM_W-1:0] dvd_reg;
    logic [CNT_W-1:0] rem_reg;
    logic [BC_W-1:0]  bit_cnt_reg;
    logic             out_vld_reg;
    logic [SAMPLE_W-1:0] mean_reg;
    logic [SAMPLE_W-1:0] wavg_reg;

    logic             issue;
    logic [PW-1:0]    addr_sum;
    logic [IDX_W-1:0] rd_addr;
    logic [SUM_W-1:0] sum_next;
    logic [SUM_W-1:0] sum_mag;
    logic [SAMPLE_W:0] pair_sum;
    logic [SAMPLE_W-1:0] acc_next;
    logic [CNT_W:0]   rem_sh;
    logic             q_bit;
    logic [CNT_W:0]   rem_sub;
    logic [SUM_W-1:0] quo_signed;
    logic             out_free;

    assign job      = pop_data;
    assign pop      = (state_reg == ST_IDLE) && !q_empty;
    assign issue    = (state_reg == ST_WALK) && (rd_idx_reg < cnt_reg);
    assign addr_sum = PW'(base_reg) + PW'(rd_idx_reg);
    assign rd_addr  = (addr_sum >= MAX_P) ? IDX_W'(addr_sum - MAX_P) : IDX_W'(addr_sum);

    always_ff @(posedge clk)
    begin
        if (pop)
            mem_reg[job.slot] <= job.sample;
        if (issue)
            rd_data_reg <= mem_reg[rd_addr];
    end

    // Running sum and floor-halving accumulator on the beat just read
    assign sum_next = sum_reg + {{(SUM_W-SAMPLE_W){rd_data_reg[SAMPLE_W-1]}}, rd_data_reg};
    assign sum_mag  = sum_next[SUM_W-1] ? (~sum_next + SUM_W'(1)) : sum_next;
    assign pair_sum = {acc_reg[SAMPLE_W-1], acc_reg} + {rd_data_reg[SAMPLE_W-1], rd_data_reg};
    assign acc_next = first_reg ? rd_data_reg : pair_sum[SAMPLE_W:1];

    // One restoring division step per cycle
    assign rem_sh  = {rem_reg, dvd_reg[SUM_W-1]};
    assign q_bit   = (rem_sh >= {1'b0, cnt_reg});
    assign rem_sub = rem_sh - {1'b0, cnt_reg};

    assign quo_signed = neg_reg ? (~dvd_reg + SUM_W'(1)) : dvd_reg;
    assign out_free   = !out_vld_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            data_vld_reg  <= 1'b0;
            out_vld_reg   <= 1'b0;
            cnt_reg       <= '0;
            base_reg      <= '0;
            rd_idx_reg    <= '0;
            data_last_reg <= 1'b0;
            first_reg     <= 1'b0;
            bit_cnt_reg   <= '0;
        end
        else
        begin
            data_vld_reg <= issue;
            if (issue)
            begin
                rd_idx_reg    <= rd_idx_reg + CNT_W'(1);
                data_last_reg <= (rd_idx_reg + CNT_W'(1) == cnt_reg);
            end

            if ((state_reg == ST_FINISH) && out_free)
                out_vld_reg <= 1'b1;
            else if (!out_stall)
                out_vld_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (pop)
                    begin
                        cnt_reg    <= job.count;
                        base_reg   <= job.base;
                        rd_idx_reg <= '0;
                        first_reg  <= 1'b1;
                        sum_reg    <= '0;
                        state_reg  <= ST_WALK;
                    end
                end
                ST_WALK:
                begin
                    if (data_vld_reg)
                    begin
                        sum_reg   <= sum_next;
                        acc_reg   <= acc_next;
                        first_reg <= 1'b0;
                        if (data_last_reg)
                        begin
                            neg_reg     <= sum_next[SUM_W-1];
                            dvd_reg     <= sum_mag;
                            rem_reg     <= '0;
                            bit_cnt_reg <= '0;
                            state_reg   <= ST_DIV;
                        end
                    end
                end
                ST_DIV:
                begin
                    dvd_reg     <= {dvd_reg[SUM_W-2:0], q_bit};
                    rem_reg     <= q_bit ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
                    bit_cnt_reg <= bit_cnt_reg + BC_W'(1);
                    if (bit_cnt_reg == BC_W'(SUM_W - 1))
                        state_reg <= ST_FINISH;
                end
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        mean_reg  <= quo_signed[SAMPLE_W-1:0];
                        wavg_reg  <= acc_reg;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid      = out_vld_reg;
    assign mean_value     = mean_reg;
    assign weighted_value = wavg_reg;

endmodule

// ===== rtl/windowed_and_weighted_average_core.sv =====
// The back end takes one job at a time; its pace is set by the
// serial walk of the sample store through its single read port and the 21-step divider.
// A two-entry job queue lets the front take up to two further samples meanwhile.
// Reset (rst_n low, asynchronous): window size 8, window empty, queue and output valid cleared.
// -----------------------------------------------------------------------------
// windowed_and_weighted_average_core
// Moving mean and binary-weighted average of signed Q8.8 samples.
// -----------------------------------------------------------------------------
module windowed_and_weighted_average_core
    import wwa_pkg::*;
#(
    parameter int MAX_WINDOW = DEFAULT_MAX_WINDOW
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [SAMPLE_W-1:0]   sample,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [SAMPLE_W-1:0]   mean_value,
    output logic [SAMPLE_W-1:0]   weighted_value,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int JOB_W = SAMPLE_W + 2 * IDX_W + CNT_W;

    logic             push;
    logic [JOB_W-1:0] push_data;
    logic             q_full;
    logic             pop;
    logic [JOB_W-1:0] pop_data;
    logic             q_empty;

    wwa_front #(
        .MAX_WINDOW (MAX_WINDOW),
        .IDX_W      (IDX_W),
        .JOB_W      (JOB_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .sample    (sample),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .push      (push),
        .push_data (push_data),
        .q_full    (q_full)
    );

    wwa_queue #(
        .DATA_W (JOB_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (q_empty)
    );

    wwa_back #(
        .MAX_WINDOW (MAX_WINDOW),
        .IDX_W      (IDX_W),
        .JOB_W      (JOB_W)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_empty        (q_empty),
        .pop_data       (pop_data),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .mean_value     (mean_value),
        .weighted_value (weighted_value)
    );

endmodule

// ===== rtl/wwa_checker.sv =====
// -----------------------------------------------------------------------------
// wwa_checker
// Port-level checks on the average core: output beat holds under stall, and
// result beats never outnumber sample beats nor run beyond the core's capacity.
// -----------------------------------------------------------------------------
module wwa_checker
    import wwa_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input logic [SAMPLE_W-1:0] mean_value,
    input logic [SAMPLE_W-1:0] weighted_value
);

    // Queue entries, one job in the back end and one held result
    localparam int CAPACITY = QUEUE_DEPTH + 2;
    localparam int PEND_W   = $clog2(CAPACITY + 1) + 1;

    logic              in_beat;
    logic              out_beat;
    logic [PEND_W-1:0] pend_reg, pend_next;

    assign in_beat  = in_valid && !in_stall;
    assign out_beat = out_valid && !out_stall;

    always_comb
    begin
        pend_next = pend_reg;
        if (in_beat && !out_beat)
            pend_next = pend_reg + PEND_W'(1);
        else if (!in_beat && out_beat)
            pend_next = pend_reg - PEND_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= '0;
        else
            pend_reg <= pend_next;
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(mean_value) && $stable(weighted_value))
        else $error("result payload changed while stalled");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != '0)
        else $error("result offered with no sample outstanding");

    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= PEND_W'(CAPACITY))
        else $error("more samples outstanding than the core can hold");

endmodule

bind windowed_and_weighted_average_core wwa_checker u_wwa_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .mean_value     (mean_value),
    .weighted_value (weighted_value)
);
